// File: rtl/spfp_pkg.sv
// Shared types and constants for the serial parameter frame parser.
package spfp_pkg;

  // Header bytes that open a command
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  // Command codes
  localparam logic [7:0] CMD_SEND    = 8'd1;
  localparam logic [7:0] CMD_CAPTURE = 8'd2;
  localparam logic [7:0] CMD_BEEP    = 8'd3;

  // Tail byte that commits a captured frame
  localparam logic [7:0] TAIL_OK = 8'd2;

  // Frame event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_COMMIT   = 2'd1;
  localparam logic [1:0] EV_BAD_TAIL = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [1:0]  frame_event;
    logic        cmd_seen;
    logic [7:0]  cmd_code;
    logic [3:0]  param_index;
    logic [31:0] param_value;
    logic        beep_on;
    logic        send_request;
    logic        last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic word_start;  // fetch word 0
    logic word_next;   // fetch the following word
    logic show_word;   // output shows a word item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic commit;     // last byte committed a frame
    logic word_last;  // current word is the final one
  } sts_t;

endpackage

// File: rtl/spfp_if.sv
// Valid/ready channel interfaces for the input byte and the result item.
interface spfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  frame_event;
  logic        cmd_seen;
  logic [7:0]  cmd_code;
  logic [3:0]  param_index;
  logic [31:0] param_value;
  logic        beep_on;
  logic        send_request;
  logic        last;

  modport source (output valid, output kind, output frame_event, output cmd_seen,
                  output cmd_code, output param_index, output param_value,
                  output beep_on, output send_request, output last, input ready);
  modport sink   (input valid, input kind, input frame_event, input cmd_seen,
                  input cmd_code, input param_index, input param_value,
                  input beep_on, input send_request, input last, output ready);
endinterface

// File: rtl/spfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spfp_ctrl.sv
// Controller: sequences input transfer, status item and parameter word items.
module spfp_ctrl
  import spfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STATUS = 2'd1;
  localparam logic [1:0] ST_WORD   = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_STATUS;
        end
      end
      ST_STATUS: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.commit) begin
            cmd_o.word_start = 1'b1;
            state_d          = ST_WORD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WORD: begin
        out_valid_o     = 1'b1;
        cmd_o.show_word = 1'b1;
        if (out_ready_i) begin
          if (sts_i.word_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.word_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/spfp_datapath.sv
// Datapath: header tracking, payload capture into byte-lane RAMs, result fields.
module spfp_datapath
  import spfp_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 56,
  parameter int WORD_COUNT    = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output out_item_t  item_o
);

  localparam int CW         = $clog2(PAYLOAD_BYTES + 1);
  localparam int LANE_BYTES = (PAYLOAD_BYTES + 3) / 4;
  localparam int LANE_DEPTH = (LANE_BYTES > WORD_COUNT) ? LANE_BYTES : WORD_COUNT;
  localparam int AW         = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;

  logic [7:0]    prev_q, prev_prev_q;
  logic          cap_q, cap_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          commit_q;
  logic [3:0]    widx_q, widx_d;

  // Status item payload, captured on the input transfer
  logic [1:0] ev_q, ev_d;
  logic       seen_q, seen_d;
  logic [7:0] code_q, code_d;
  logic       beep_q, beep_d;
  logic       send_q, send_d;
  logic       commit_d;
  logic       store;

  logic [AW-1:0] waddr, raddr;
  logic          rd_en;
  logic [31:0]   word;

  // Capture step first, then the header check
  always_comb begin
    ev_d     = EV_NONE;
    commit_d = 1'b0;
    beep_d   = 1'b0;
    send_d   = 1'b0;
    seen_d   = 1'b0;
    store    = 1'b0;
    cap_d    = cap_q;
    cnt_d    = cnt_q;
    if (cap_q) begin
      if (cnt_q < CW'(PAYLOAD_BYTES)) begin
        store = 1'b1;
        cnt_d = cnt_q + CW'(1);
      end else begin
        cnt_d = '0;
        cap_d = 1'b0;
        if (rx_byte_i == TAIL_OK) begin
          commit_d = 1'b1;
          ev_d     = EV_COMMIT;
          beep_d   = 1'b1;
          send_d   = 1'b1;
        end else begin
          ev_d = EV_BAD_TAIL;
        end
      end
    end
    if (prev_prev_q == HDR_FIRST && prev_q == HDR_SECOND) begin
      seen_d = 1'b1;
      case (rx_byte_i)
        CMD_SEND: begin
          send_d = 1'b1;
          beep_d = 1'b1;
        end
        CMD_CAPTURE: begin
          cnt_d  = '0;
          cap_d  = 1'b1;
          beep_d = 1'b1;
        end
        CMD_BEEP: begin
          beep_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
    code_d = seen_d ? rx_byte_i : 8'd0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      prev_prev_q <= '0;
      cap_q       <= 1'b0;
      cnt_q       <= '0;
      commit_q    <= 1'b0;
      widx_q      <= '0;
    end else begin
      if (cmd_i.take) begin
        prev_q      <= rx_byte_i;
        prev_prev_q <= prev_q;
        cap_q       <= cap_d;
        cnt_q       <= cnt_d;
        commit_q    <= commit_d;
      end
      widx_q <= widx_d;
    end
  end

  // Status payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ev_q   <= ev_d;
      seen_q <= seen_d;
      code_q <= code_d;
      beep_q <= beep_d;
      send_q <= send_d;
    end
  end

  // Word index and read address
  always_comb begin
    widx_d = widx_q;
    if (cmd_i.word_start) begin
      widx_d = '0;
    end else if (cmd_i.word_next) begin
      widx_d = widx_q + 4'd1;
    end
  end

  assign rd_en = cmd_i.word_start | cmd_i.word_next;
  assign raddr = AW'(widx_d);
  assign waddr = AW'(cnt_q >> 2);

  // Four byte lanes: payload byte i sits in lane i mod 4 at address i / 4
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic lane_we;
    assign lane_we = cmd_i.take & store & (cnt_q[1:0] == 2'(l));

    spfp_ram #(
      .WIDTH (8),
      .DEPTH (LANE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we),
      .waddr_i (waddr),
      .wdata_i (rx_byte_i),
      .re_i    (rd_en),
      .raddr_i (raddr),
      .rdata_o (word[8*l +: 8])
    );
  end

  assign sts_o.commit    = commit_q;
  assign sts_o.word_last = (widx_q == 4'(WORD_COUNT - 1));

  // Result fields
  always_comb begin
    item_o = '0;
    if (cmd_i.show_word) begin
      item_o.kind        = KIND_WORD;
      item_o.param_index = widx_q;
      item_o.param_value = word;
      item_o.last        = sts_o.word_last;
    end else begin
      item_o.kind         = KIND_STATUS;
      item_o.frame_event  = ev_q;
      item_o.cmd_seen     = seen_q;
      item_o.cmd_code     = code_q;
      item_o.beep_on      = beep_q;
      item_o.send_request = send_q;
      item_o.last         = ~commit_q;
    end
  end

endmodule

// File: rtl/serial_param_frame_parser.sv
// Serial parameter frame parser top level: controller, datapath and channels.
//
// Each received byte is one input transfer and yields one status item; a byte
// that commits a captured frame is followed by WORD_COUNT parameter word items.
// A plain byte passes through its transfer and its status item, and a committing
// byte goes on into its word items: each word is one read of four byte-lane
// RAMs that hold the payload, fetched one word per cycle while the sink is
// ready. A new byte is taken only once all results of the previous byte have
// been transferred. The payload RAMs need no clearing after reset; words that
// reach past the captured payload read undefined data.
module serial_param_frame_parser
  import spfp_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 56,
  parameter int WORD_COUNT    = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  spfp_in_if.sink           in_i,
  spfp_out_if.source        out_o
);

  cmd_t      cmd;
  sts_t      sts;
  out_item_t item;
  logic      in_ready, out_valid;

  spfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spfp_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .WORD_COUNT    (WORD_COUNT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (in_i.rx_byte),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .item_o    (item)
  );

  // Channel wiring
  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.kind         = item.kind;
  assign out_o.frame_event  = item.frame_event;
  assign out_o.cmd_seen     = item.cmd_seen;
  assign out_o.cmd_code     = item.cmd_code;
  assign out_o.param_index  = item.param_index;
  assign out_o.param_value  = item.param_value;
  assign out_o.beep_on      = item.beep_on;
  assign out_o.send_request = item.send_request;
  assign out_o.last         = item.last;

endmodule

// File: rtl/spfp_checker.sv
// Port-level assertions for the serial parameter frame parser, with bind.
module spfp_checker
  import spfp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       kind_i,
  input logic [1:0] frame_event_i,
  input logic       cmd_seen_i,
  input logic       beep_on_i,
  input logic       send_request_i,
  input logic [3:0] param_index_i,
  input logic       last_i
);

  logic out_xfer;
  assign out_xfer = out_valid_i & out_ready_i;

  // No new byte is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("input ready while a result is pending");

  // A committing status item is followed at once by word 0
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !kind_i && !last_i) |=> (out_valid_i && kind_i && param_index_i == 4'd0))
    else $error("word 0 does not follow a committing status item");

  // Word items run with consecutive indexes
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && kind_i && !last_i) |=>
      (out_valid_i && kind_i && param_index_i == $past(param_index_i) + 4'd1))
    else $error("word index does not advance");

  // A status item continues into words exactly when the frame committed
  a_commit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !kind_i) |-> ((frame_event_i == EV_COMMIT) == !last_i))
    else $error("status last flag disagrees with frame event");

  // Word items carry no status flags
  a_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i) |->
      (frame_event_i == EV_NONE && !cmd_seen_i && !beep_on_i && !send_request_i))
    else $error("status flags set in a word item");

endmodule

bind serial_param_frame_parser spfp_checker u_spfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .frame_event_i  (out_o.frame_event),
  .cmd_seen_i     (out_o.cmd_seen),
  .beep_on_i      (out_o.beep_on),
  .send_request_i (out_o.send_request),
  .param_index_i  (out_o.param_index),
  .last_i         (out_o.last)
);
